// ===== hdl/linear_probe_hash_dictionary_defines.svh =====
// ----------------------------------------------------------------------------
// Linear probe hash dictionary: assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_DICTIONARY_DEFINES_SVH
`define LINEAR_PROBE_HASH_DICTIONARY_DEFINES_SVH

// same-cycle implication, quiet during reset
`define LPHD_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lphd check failed");

// next-cycle implication, quiet during reset
`define LPHD_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lphd check failed");

// next-cycle implication, active during reset
`define LPHD_ASSERT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("lphd check failed");

`endif

// ===== hdl/lphd_pkg.sv =====
// ----------------------------------------------------------------------------
// lphd_pkg
// Types and constants of the linear probe hash dictionary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lphd_pkg;
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int KEY_BYTES   = 8;
  localparam int KEY_W       = 8 * KEY_BYTES;
  localparam int VALUE_BITS  = 32;
  localparam int HASH_W      = 32;
  localparam int LEN_W       = 4;
  localparam int CFG_W       = 9;
  localparam int STEP_W      = $clog2(KEY_BYTES) + 1;
  localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;

  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_GET   = 2'd1;
  localparam logic [1:0] REQ_DEL   = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic CFG_TABLE_SIZE = 1'b0;
  localparam logic CFG_KEY_LIMIT  = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;
  localparam logic [2:0] ST_DELETED   = 3'd6;
  localparam logic [2:0] ST_CLEARED   = 3'd7;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [VALUE_BITS-1:0] found_value;
    logic [CNT_W-1:0]      entry_total;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] value;
    logic [HASH_W-1:0]     hash;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    entry_t           wdata;
  } store_req_t;
endpackage
`default_nettype wire

// ===== hdl/lphd_hash.sv =====
// ----------------------------------------------------------------------------
// lphd_hash
// Key hash, one byte per cycle (h = h*33 + byte, zero bytes skipped).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lphd_hash (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [lphd_pkg::KEY_W-1:0]  key_in,
  output logic                             done,
  output logic [lphd_pkg::HASH_W-1:0]      hash
);
  logic                             running;
  logic [lphd_pkg::STEP_W-1:0]      cnt;
  logic [lphd_pkg::KEY_W-1:0]       sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        sh      <= key_in;
        hash    <= lphd_pkg::HASH_SEED;
      end else if (running) begin
        if (sh[7:0] != 8'd0) begin
          hash <= (hash << 5) + hash + {{(lphd_pkg::HASH_W-8){1'b0}}, sh[7:0]};
        end
        sh  <= sh >> 8;
        cnt <= cnt + 1'b1;
        if (cnt == lphd_pkg::STEP_W'(lphd_pkg::KEY_BYTES - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lphd_mod.sv =====
// ----------------------------------------------------------------------------
// lphd_mod
// Restoring remainder of a hash by the table size, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lphd_mod (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [lphd_pkg::HASH_W-1:0] dividend,
  input  wire logic [lphd_pkg::CNT_W-1:0]  divisor,
  output logic                             done,
  output logic [lphd_pkg::IDX_W-1:0]       rem
);
  localparam int BIT_W = $clog2(lphd_pkg::HASH_W);

  logic                          running;
  logic [BIT_W-1:0]              cnt;
  logic [lphd_pkg::HASH_W-1:0]   dv;
  logic [lphd_pkg::CNT_W-1:0]    dsr;
  logic [lphd_pkg::CNT_W-1:0]    trial;
  logic [lphd_pkg::CNT_W-1:0]    diff;

  always_comb begin
    trial = {rem, dv[lphd_pkg::HASH_W-1]};
    diff  = (trial >= dsr) ? (trial - dsr) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        dv      <= dividend;
        dsr     <= divisor;
        rem     <= '0;
      end else if (running) begin
        rem <= diff[lphd_pkg::IDX_W-1:0];
        dv  <= dv << 1;
        cnt <= cnt + 1'b1;
        if (cnt == BIT_W'(lphd_pkg::HASH_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lphd_store.sv =====
// ----------------------------------------------------------------------------
// lphd_store
// Slot memory: key, value and key hash, one write and one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lphd_store (
  input  wire logic                 clk,
  input  wire lphd_pkg::store_req_t req,
  output lphd_pkg::entry_t          rdata
);
  lphd_pkg::entry_t mem [lphd_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/linear_probe_hash_dictionary.sv =====
// Clear and rejected sets answer from idle; others hash the key, take its home slot,
//   compare occupied slots in turn and end at a match, an empty slot or the size
//   limit; delete then recomputes the home of each cluster slot walked after it.
// Throughput: one item at a time; the bit-serial remainder unit sets the pace.
// Reset: synchronous, clears used flags and entry count; table_size=256, key_limit=9.
// The receiver cannot stall: each result shows for one cycle with done.
// ----------------------------------------------------------------------------
// linear_probe_hash_dictionary
// Open-addressing key/value table with linear probing and backward-shift delete.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_dictionary (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire lphd_pkg::req_t                req,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [lphd_pkg::CFG_W-1:0]    cfg_data,
  output logic                               done,
  output lphd_pkg::rsp_t                     rsp
);
  localparam int IW = lphd_pkg::IDX_W;
  localparam int CW = lphd_pkg::CNT_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_HASH  = 8'b0000_0010,
    S_HOME  = 8'b0000_0100,
    S_PROBE = 8'b0000_1000,
    S_PCMP  = 8'b0001_0000,
    S_SCHK  = 8'b0010_0000,
    S_SLAT  = 8'b0100_0000,
    S_SMOD  = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration
  logic [CW-1:0]              table_size;
  logic [lphd_pkg::LEN_W-1:0] key_limit;
  logic [CW-1:0]              size_eff;

  // request held for the whole walk
  logic [1:0]                      op;
  logic [lphd_pkg::KEY_W-1:0]      key_r;
  logic [lphd_pkg::VALUE_BITS-1:0] val_r;
  logic [lphd_pkg::HASH_W-1:0]     hash_r;
  logic [CW-1:0]                   size_r;

  // walk pointers
  logic [IW-1:0] idx;
  logic [IW-1:0] hole;
  logic [CW-1:0] n;
  logic [CW-1:0] count;

  // used flags, one per slot, cleared at once
  logic [lphd_pkg::TABLE_DEPTH-1:0] used;

  // key cleanup
  logic [lphd_pkg::KEY_W-1:0] key_clean;
  logic [lphd_pkg::LEN_W-1:0] key_len;
  logic                       ended;

  // units
  logic                        hash_start, hash_done;
  logic                        hash_go;
  logic [lphd_pkg::HASH_W-1:0] hash_out;
  logic                        mod_start, mod_done;
  logic [lphd_pkg::HASH_W-1:0] mod_in;
  logic [IW-1:0]               home;
  lphd_pkg::store_req_t        sreq;
  lphd_pkg::entry_t            rd;

  logic [IW-1:0] idx_inc;
  logic [IW-1:0] hole_inc;
  logic          move;

  always_comb begin
    if (table_size == '0) begin
      size_eff = CW'(1);
    end else if (table_size > CW'(lphd_pkg::TABLE_DEPTH)) begin
      size_eff = CW'(lphd_pkg::TABLE_DEPTH);
    end else begin
      size_eff = table_size;
    end
  end

  always_comb begin
    key_clean = '0;
    key_len   = '0;
    ended     = 1'b0;
    for (int i = 0; i < lphd_pkg::KEY_BYTES; i++) begin
      if (req.key[8*i +: 8] == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        key_clean[8*i +: 8] = req.key[8*i +: 8];
        key_len             = key_len + 1'b1;
      end
    end
  end

  // next slot with wraparound at the effective size
  assign idx_inc  = (({1'b0, idx} + 1'b1) == size_r) ? '0 : idx + 1'b1;
  assign hole_inc = idx_inc;

  // backward shift: entry at idx may fill the hole unless its home lies between
  always_comb begin
    if (hole < idx) begin
      move = (home <= hole) || (home > idx);
    end else begin
      move = (home <= hole) && (home > idx);
    end
  end

  assign busy   = (state != S_IDLE);
  assign mod_in = (state == S_SLAT) ? rd.hash : hash_out;

  lphd_hash u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .key_in (key_r),
    .done   (hash_done),
    .hash   (hash_out)
  );

  lphd_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_in),
    .divisor  (size_r),
    .done     (mod_done),
    .rem      (home)
  );

  lphd_store u_store (
    .clk   (clk),
    .req   (sreq),
    .rdata (rd)
  );

  // memory requests and unit kicks
  always_comb begin
    sreq       = '0;
    sreq.raddr = idx;
    sreq.waddr = idx;
    sreq.wdata = '{key: key_r, value: val_r, hash: hash_r};
    mod_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        mod_start = 1'b0;
      end
      S_HASH: begin
        mod_start = hash_done;
      end
      S_HOME: begin
        mod_start = 1'b0;
      end
      S_PROBE: begin
        if (n != size_r) begin
          if (used[idx]) begin
            sreq.re = 1'b1;
          end else if (op == lphd_pkg::REQ_SET) begin
            sreq.we = 1'b1;
          end
        end
      end
      S_PCMP: begin
        if (rd.key == key_r && op == lphd_pkg::REQ_SET) begin
          sreq.we = 1'b1;
        end
      end
      S_SCHK: begin
        sreq.re = (n != size_r) && used[idx];
      end
      S_SLAT: begin
        mod_start = 1'b1;
      end
      S_SMOD: begin
        sreq.waddr = hole;
        sreq.wdata = rd;
        sreq.we    = mod_done && move;
      end
      default: begin
        sreq.re = 1'b0;
      end
    endcase
  end

  // hash unit start is a pulse on the cycle after the request is taken
  assign hash_start = hash_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      table_size <= CW'(lphd_pkg::TABLE_DEPTH);
      key_limit  <= lphd_pkg::LEN_W'(9);
      used       <= '0;
      count      <= '0;
      done       <= 1'b0;
      hash_go    <= 1'b0;
    end else begin
      done    <= 1'b0;
      hash_go <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == lphd_pkg::CFG_TABLE_SIZE) begin
          table_size <= cfg_data;
        end else begin
          key_limit <= cfg_data[lphd_pkg::LEN_W-1:0];
        end
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op     <= req.req_type;
            key_r  <= key_clean;
            val_r  <= req.value;
            size_r <= size_eff;
            rsp.found_value <= '0;
            if (req.req_type == lphd_pkg::REQ_CLEAR) begin
              used            <= '0;
              count           <= '0;
              rsp.status      <= lphd_pkg::ST_CLEARED;
              rsp.entry_total <= '0;
              done            <= 1'b1;
            end else if (req.req_type == lphd_pkg::REQ_SET && key_len >= key_limit) begin
              rsp.status      <= lphd_pkg::ST_TOO_LONG;
              rsp.entry_total <= count;
              done            <= 1'b1;
            end else begin
              hash_go <= 1'b1;
              state   <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            hash_r <= hash_out;
            state  <= S_HOME;
          end
        end
        S_HOME: begin
          if (mod_done) begin
            idx   <= home;
            n     <= '0;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (n == size_r) begin
            rsp.status      <= (op == lphd_pkg::REQ_SET) ? lphd_pkg::ST_FULL
                                                         : lphd_pkg::ST_NOT_FOUND;
            rsp.entry_total <= count;
            done            <= 1'b1;
            state           <= S_IDLE;
          end else if (!used[idx]) begin
            if (op == lphd_pkg::REQ_SET) begin
              used[idx]       <= 1'b1;
              count           <= count + 1'b1;
              rsp.status      <= lphd_pkg::ST_INSERTED;
              rsp.entry_total <= count + 1'b1;
            end else begin
              rsp.status      <= lphd_pkg::ST_NOT_FOUND;
              rsp.entry_total <= count;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_PCMP;
          end
        end
        S_PCMP: begin
          if (rd.key == key_r) begin
            case (op)
              lphd_pkg::REQ_SET: begin
                rsp.status      <= lphd_pkg::ST_UPDATED;
                rsp.entry_total <= count;
                done            <= 1'b1;
                state           <= S_IDLE;
              end
              lphd_pkg::REQ_GET: begin
                rsp.status      <= lphd_pkg::ST_FOUND;
                rsp.found_value <= rd.value;
                rsp.entry_total <= count;
                done            <= 1'b1;
                state           <= S_IDLE;
              end
              default: begin
                // delete: open the hole, then walk the rest of the cluster
                used[idx] <= 1'b0;
                count     <= count - 1'b1;
                hole      <= idx;
                idx       <= idx_inc;
                n         <= '0;
                state     <= S_SCHK;
              end
            endcase
          end else begin
            idx   <= idx_inc;
            n     <= n + 1'b1;
            state <= S_PROBE;
          end
        end
        S_SCHK: begin
          if (n == size_r || !used[idx]) begin
            rsp.status      <= lphd_pkg::ST_DELETED;
            rsp.entry_total <= count;
            done            <= 1'b1;
            state           <= S_IDLE;
          end else begin
            state <= S_SLAT;
          end
        end
        S_SLAT: begin
          state <= S_SMOD;
        end
        S_SMOD: begin
          if (mod_done) begin
            if (move) begin
              used[hole] <= 1'b1;
              used[idx]  <= 1'b0;
              hole       <= idx;
            end
            idx   <= hole_inc;
            n     <= n + 1'b1;
            state <= S_SCHK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lphd_checker.sv =====
// ----------------------------------------------------------------------------
// lphd_checker
// Port-level checks of the dictionary, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "linear_probe_hash_dictionary_defines.svh"
module lphd_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire lphd_pkg::req_t req,
  input wire logic           done,
  input wire lphd_pkg::rsp_t rsp
);
  logic clear_take;
  logic clear_rsp;

  assign clear_take = start && !busy && req.req_type == lphd_pkg::REQ_CLEAR;
  assign clear_rsp  = done && rsp.status == lphd_pkg::ST_CLEARED && rsp.entry_total == '0;

  `LPHD_ASSERT_RST(a_reset_quiet, rst, !done && !busy)
  `LPHD_ASSERT_NXT(a_clear_now, clear_take, clear_rsp)
  `LPHD_ASSERT_NOW(a_value_zero, done && rsp.status != lphd_pkg::ST_FOUND, rsp.found_value == '0)
  `LPHD_ASSERT_NOW(a_idle_on_done, done, !busy)
  `LPHD_ASSERT_NOW(a_insert_count, done && rsp.status == lphd_pkg::ST_INSERTED, rsp.entry_total != '0)
endmodule

bind linear_probe_hash_dictionary lphd_checker u_lphd_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);
`default_nettype wire
